/* hdl/serial_command_line_parser_unit_macros.svh */
// Assertion macros of the command line parser, used by its back end.
`ifndef SERIAL_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define SERIAL_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCLP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sclp_pkg.sv */
// Types and constants of the serial command line parser.
`timescale 1ns / 1ps
package sclp_pkg;

  typedef enum logic [2:0] {
    CMD_SCAN    = 3'd0,
    CMD_ADC     = 3'd1,
    CMD_LED     = 3'd2,
    CMD_UNKNOWN = 3'd3,
    CMD_BAD     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_BS   = 2'd1,
    KIND_EOL  = 2'd2
  } kind_e;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } req_t;

  // One parsed line; command sits in the low bits.
  typedef struct packed {
    logic               led_on;
    logic signed [31:0] led_index;
    cmd_e               command;
  } result_t;

  localparam int unsigned RESULT_W    = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Keywords, right aligned, first character in the highest used byte.
  localparam logic [31:0] WORD_SCAN = 32'("SCAN");
  localparam logic [31:0] WORD_ADC  = 32'("ADC");
  localparam logic [31:0] WORD_LED  = 32'("LED");
  localparam logic [31:0] WORD_ON   = 32'("ON");
  localparam logic [31:0] WORD_OFF  = 32'("OFF");
  localparam logic [2:0]  LEN_SCAN  = 3'd4;
  localparam logic [2:0]  LEN_ADC   = 3'd3;
  localparam logic [2:0]  LEN_LED   = 3'd3;
  localparam logic [2:0]  LEN_ON    = 3'd2;
  localparam logic [2:0]  LEN_OFF   = 3'd3;
  localparam logic [2:0]  LED_TOKENS = 3'd3;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

endpackage

/* hdl/sclp_front.sv */
// Front end: takes received bytes, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module sclp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic [7:0]      s_data_i,
  output logic            s_ready_o,
  output logic            req_valid_o,
  output sclp_pkg::req_t  req_o,
  input  logic            req_ready_i
);

  localparam int unsigned PtrW  = (sclp_pkg::QUEUE_DEPTH > 1) ? $clog2(sclp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(sclp_pkg::QUEUE_DEPTH + 1);

  sclp_pkg::req_t   q_mem [sclp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push, pop;
  sclp_pkg::req_t   cls;

  always_comb begin
    cls.data = s_data_i;
    case (s_data_i)
      sclp_pkg::CH_BS: cls.kind = sclp_pkg::KIND_BS;
      sclp_pkg::CH_LF,
      sclp_pkg::CH_CR: cls.kind = sclp_pkg::KIND_EOL;
      default:         cls.kind = sclp_pkg::KIND_CHAR;
    endcase
  end

  assign s_ready_o   = (fill_q != FillW'(sclp_pkg::QUEUE_DEPTH));
  assign req_valid_o = (fill_q != '0);
  assign req_o       = q_mem[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(sclp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(sclp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

/* hdl/sclp_back.sv */
// Back end: line store, end-of-line token scanner and result register.
`timescale 1ns / 1ps
`include "serial_command_line_parser_unit_macros.svh"
module sclp_back #(
  parameter int unsigned LINE_LENGTH = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  sclp_pkg::req_t    req_i,
  output logic              req_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output sclp_pkg::result_t m_result_o
);

  localparam int unsigned CntW  = $clog2(LINE_LENGTH + 1);
  localparam int unsigned AddrW = $clog2(LINE_LENGTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    NP_LEAD,
    NP_SIGN,
    NP_DIGIT,
    NP_STOP
  } num_phase_e;

  function automatic logic word_char_ok(input logic [31:0] word, input logic [2:0] wlen,
                                        input logic [2:0] pos, input logic [7:0] c);
    logic [1:0] sel;
    begin
      sel = 2'(wlen - 3'd1 - pos);
      return (pos < wlen) && (c == word[sel*8 +: 8]);
    end
  endfunction

  logic [7:0]        line_mem [LINE_LENGTH];
  logic [7:0]        rdata_q;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   rd_ptr_q, rd_ptr_d;
  logic              rd_vld_q, rd_vld_d;
  logic              issue, mem_we, load;

  // tokenizer state
  logic              in_tok_q, in_tok_d, tk_in_tok;
  logic [2:0]        ntok_q, ntok_d, tk_ntok;
  logic [2:0]        pos_q, pos_d, tk_pos;
  logic              m_scan_q, m_scan_d, tk_m_scan;
  logic              m_adc_q, m_adc_d, tk_m_adc;
  logic              m_led_q, m_led_d, tk_m_led;
  logic              m_on_q, m_on_d, tk_m_on;
  logic              m_off_q, m_off_d, tk_m_off;
  logic [2:0]        len0_q, len0_d, tk_len0;
  logic [2:0]        len2_q, len2_d, tk_len2;
  num_phase_e        ph_q, ph_d, tk_ph;
  logic              neg_q, neg_d, tk_neg;
  logic [31:0]       mag_q, mag_d, tk_mag;

  logic              out_vld_q, out_vld_d;
  sclp_pkg::result_t res_q, res_d, res_fin;

  // per-character scanner step on the byte just read
  logic        start;
  logic [1:0]  tid;
  logic [2:0]  pos, pos_nx;
  num_phase_e  ph_c;
  logic [31:0] mag_c;
  logic        neg_c;
  logic        is_digit, is_ws;
  logic [35:0] acc;
  logic [31:0] acc_sat;

  always_comb begin
    start    = !in_tok_q;
    tid      = start ? ((ntok_q >= 3'd3) ? 2'd3 : ntok_q[1:0]) : 2'(ntok_q - 3'd1);
    pos      = start ? 3'd0 : pos_q;
    pos_nx   = (pos == 3'd7) ? 3'd7 : pos + 3'd1;
    ph_c     = start ? NP_LEAD : ph_q;
    mag_c    = start ? 32'd0 : mag_q;
    neg_c    = start ? 1'b0 : neg_q;
    is_digit = (rdata_q >= sclp_pkg::CH_ZERO) && (rdata_q <= sclp_pkg::CH_NINE);
    is_ws    = (rdata_q == sclp_pkg::CH_TAB) || (rdata_q == sclp_pkg::CH_VT) ||
               (rdata_q == sclp_pkg::CH_FF);
    // mag * 10 + digit, clamped at 2^31
    acc      = ({4'd0, mag_c} << 3) + ({4'd0, mag_c} << 1) + {32'd0, rdata_q[3:0]};
    acc_sat  = (acc > {4'd0, sclp_pkg::MAG_LIMIT}) ? sclp_pkg::MAG_LIMIT : acc[31:0];

    tk_in_tok = in_tok_q;
    tk_ntok   = ntok_q;
    tk_pos    = pos_q;
    tk_m_scan = m_scan_q;
    tk_m_adc  = m_adc_q;
    tk_m_led  = m_led_q;
    tk_m_on   = m_on_q;
    tk_m_off  = m_off_q;
    tk_len0   = len0_q;
    tk_len2   = len2_q;
    tk_ph     = ph_q;
    tk_neg    = neg_q;
    tk_mag    = mag_q;

    if (rdata_q == sclp_pkg::CH_SPACE) begin
      tk_in_tok = 1'b0;
    end else begin
      tk_in_tok = 1'b1;
      tk_pos    = pos_nx;
      if (start) begin
        tk_ntok = (ntok_q == 3'd4) ? 3'd4 : ntok_q + 3'd1;
      end
      case (tid)
        2'd0: begin
          tk_m_scan = (start | m_scan_q) &
                      word_char_ok(sclp_pkg::WORD_SCAN, sclp_pkg::LEN_SCAN, pos, rdata_q);
          tk_m_adc  = (start | m_adc_q) &
                      word_char_ok(sclp_pkg::WORD_ADC, sclp_pkg::LEN_ADC, pos, rdata_q);
          tk_m_led  = (start | m_led_q) &
                      word_char_ok(sclp_pkg::WORD_LED, sclp_pkg::LEN_LED, pos, rdata_q);
          tk_len0   = pos_nx;
        end
        2'd1: begin
          tk_ph  = ph_c;
          tk_mag = mag_c;
          tk_neg = neg_c;
          case (ph_c)
            NP_LEAD: begin
              if (is_ws) begin
                tk_ph = NP_LEAD;
              end else if ((rdata_q == sclp_pkg::CH_PLUS) ||
                           (rdata_q == sclp_pkg::CH_MINUS)) begin
                tk_neg = (rdata_q == sclp_pkg::CH_MINUS);
                tk_ph  = NP_SIGN;
              end else if (is_digit) begin
                tk_mag = acc_sat;
                tk_ph  = NP_DIGIT;
              end else begin
                tk_ph = NP_STOP;
              end
            end
            NP_SIGN, NP_DIGIT: begin
              if (is_digit) begin
                tk_mag = acc_sat;
                tk_ph  = NP_DIGIT;
              end else begin
                tk_ph = NP_STOP;
              end
            end
            default: tk_ph = NP_STOP;
          endcase
        end
        2'd2: begin
          tk_m_on  = (start | m_on_q) &
                     word_char_ok(sclp_pkg::WORD_ON, sclp_pkg::LEN_ON, pos, rdata_q);
          tk_m_off = (start | m_off_q) &
                     word_char_ok(sclp_pkg::WORD_OFF, sclp_pkg::LEN_OFF, pos, rdata_q);
          tk_len2  = pos_nx;
        end
        default: ;
      endcase
    end
  end

  // classification of the finished line
  always_comb begin
    res_fin.command   = sclp_pkg::CMD_UNKNOWN;
    res_fin.led_index = '0;
    res_fin.led_on    = 1'b0;
    if (ntok_q == 3'd0) begin
      res_fin.command = sclp_pkg::CMD_UNKNOWN;
    end else if (m_scan_q && (len0_q == sclp_pkg::LEN_SCAN)) begin
      res_fin.command = sclp_pkg::CMD_SCAN;
    end else if (m_adc_q && (len0_q == sclp_pkg::LEN_ADC)) begin
      res_fin.command = sclp_pkg::CMD_ADC;
    end else if (m_led_q && (len0_q == sclp_pkg::LEN_LED)) begin
      res_fin.command = sclp_pkg::CMD_BAD;
      if ((ntok_q == sclp_pkg::LED_TOKENS) &&
          ((m_on_q && (len2_q == sclp_pkg::LEN_ON)) ||
           (m_off_q && (len2_q == sclp_pkg::LEN_OFF)))) begin
        res_fin.command   = sclp_pkg::CMD_LED;
        res_fin.led_on    = m_on_q && (len2_q == sclp_pkg::LEN_ON);
        res_fin.led_index = neg_q ? (32'd0 - mag_q) :
                            ((mag_q > sclp_pkg::POS_LIMIT) ? sclp_pkg::POS_LIMIT : mag_q);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rd_ptr_d = rd_ptr_q;
    rd_vld_d = rd_vld_q;
    in_tok_d = in_tok_q;
    ntok_d   = ntok_q;
    pos_d    = pos_q;
    m_scan_d = m_scan_q;
    m_adc_d  = m_adc_q;
    m_led_d  = m_led_q;
    m_on_d   = m_on_q;
    m_off_d  = m_off_q;
    len0_d   = len0_q;
    len2_d   = len2_q;
    ph_d     = ph_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    req_ready_o = 1'b0;
    issue    = 1'b0;
    mem_we   = 1'b0;
    load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (req_i.kind)
            sclp_pkg::KIND_BS: begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            sclp_pkg::KIND_EOL: begin
              if (cnt_q >= CntW'(LINE_LENGTH)) begin
                cnt_d = '0;
              end else begin
                state_d  = ST_SCAN;
                rd_ptr_d = '0;
                rd_vld_d = 1'b0;
                in_tok_d = 1'b0;
                ntok_d   = 3'd0;
              end
            end
            default: begin
              if (cnt_q >= CntW'(LINE_LENGTH)) begin
                cnt_d = '0;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        issue    = (rd_ptr_q < cnt_q);
        rd_vld_d = issue;
        if (issue) begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (rdata_q == sclp_pkg::CH_NUL) begin
            // a stored zero ends the line
            state_d  = ST_FIN;
            rd_vld_d = 1'b0;
          end else begin
            in_tok_d = tk_in_tok;
            ntok_d   = tk_ntok;
            pos_d    = tk_pos;
            m_scan_d = tk_m_scan;
            m_adc_d  = tk_m_adc;
            m_led_d  = tk_m_led;
            m_on_d   = tk_m_on;
            m_off_d  = tk_m_off;
            len0_d   = tk_len0;
            len2_d   = tk_len2;
            ph_d     = tk_ph;
            neg_d    = tk_neg;
            mag_d    = tk_mag;
          end
        end else if (!issue) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || m_ready_i) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_vld_d = load ? 1'b1 : (m_ready_i ? 1'b0 : out_vld_q);
    res_d     = load ? res_fin : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      rd_vld_q  <= 1'b0;
      in_tok_q  <= 1'b0;
      ntok_q    <= 3'd0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_vld_q  <= rd_vld_d;
      in_tok_q  <= in_tok_d;
      ntok_q    <= ntok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    m_scan_q <= m_scan_d;
    m_adc_q  <= m_adc_d;
    m_led_q  <= m_led_d;
    m_on_q   <= m_on_d;
    m_off_q  <= m_off_d;
    len0_q   <= len0_d;
    len2_q   <= len2_d;
    ph_q     <= ph_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    res_q    <= res_d;
  end

  // line store; slots at or above the fill count are never read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[cnt_q[AddrW-1:0]] <= req_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= line_mem[rd_ptr_q[AddrW-1:0]];
    end
  end

  assign m_valid_o  = out_vld_q;
  assign m_result_o = res_q;

  `SCLP_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_q <= CntW'(LINE_LENGTH), "line count past store size")
  `SCLP_ASSERT_IMPLY(a_ptr_bound, state_q == ST_SCAN, rd_ptr_q <= cnt_q, "scan pointer past line end")
  `SCLP_ASSERT_IMPLY(a_pop_idle, req_valid_i && req_ready_o, state_q == ST_IDLE, "request taken while busy")
  `SCLP_ASSERT_NEXT(a_load_clears, load, (cnt_q == '0) && out_vld_q, "line not cleared after result")

endmodule

/* hdl/serial_command_line_parser_unit.sv */
// Top level of the serial command line parser: front end, request queue and back end.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata command, led_index, led_on
//
// A plain byte or backspace is taken by the back end while idle; the front queue holds two requests.
// On an end of line the scanner reads one stored character per cycle from the line store's
// single read port, then classifies and loads the result.
// Reset empties the line (fill count only, no clearing pass) and drops any pending result.
// A result stalled at m_axis holds the back end in its final step; bytes still queue in front.
`timescale 1ns / 1ps
module serial_command_line_parser_unit #(
  parameter int unsigned LINE_LENGTH = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] command, [34:3] led_index, [35] led_on, [39:36] zero
  output logic [sclp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic              req_valid;
  logic              req_ready;
  sclp_pkg::req_t    req;
  sclp_pkg::result_t result;

  sclp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  sclp_back #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_result_o  (result)
  );

  assign m_axis_tdata = sclp_pkg::OUT_TDATA_W'(result);

endmodule
